// ===== hdl/pfc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the byte Playfair cipher.
package pfc_pkg;

  localparam int GridSide  = 16;
  localparam int SideW     = $clog2(GridSide);
  localparam int CellCount = GridSide * GridSide;
  localparam int CellW     = $clog2(CellCount);
  localparam int SymW      = 8;
  localparam int SymCount  = 1 << SymW;
  localparam int FillW     = CellW + 1;
  localparam int OpW       = 2;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;
  localparam int SlotCount = 4;
  localparam int SlotW     = $clog2(SlotCount);

  localparam logic [SideW-1:0] StepFwd  = SideW'(1);
  localparam logic [SideW-1:0] StepBack = SideW'(GridSide - 1);

  // input item kinds
  typedef enum logic [OpW-1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_DATA   = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMarker = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDir    = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic fill_step;   // examine one more symbol in the grid fill sweep, placing it if unused
    logic look_a;      // position lookup, first symbol of the pair
    logic look_b;      // position lookup, second symbol of the pair
    logic grid_a;      // work out new cells, read grid at first cell
    logic grid_b;      // capture first byte, read grid at second cell
    logic grid_c;      // capture second byte
    logic next_pair;   // move on to the second pair
    logic emit_step;   // hand out the current slot, if kept
    logic push_empty;  // end-of-message result without a byte
  } pfc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_fill;
    logic start_pair;
    logic fill_last;
    logic more_pair;
    logic emit_go;
    logic emit_last;
    logic empty_needed;
    logic out_free;
  } pfc_stat_t;

endpackage

// ===== hdl/pfc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pfc_ctrl.sv =====
// Controller state machine: sequences key fill, pair lookups and result hand-out.
module pfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  pfc_pkg::pfc_stat_t  stat_i,
  output pfc_pkg::pfc_cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FILL  = 8'b0000_0010,
    ST_CA    = 8'b0000_0100,
    ST_CB    = 8'b0000_1000,
    ST_GA    = 8'b0001_0000,
    ST_GB    = 8'b0010_0000,
    ST_GC    = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   empty_q, empty_d;   // end-of-message empty result still owed

  always_comb begin
    state_d = state_q;
    empty_d = empty_q;
    cmd_o   = '0;
    s_ready_o = (state_q == ST_IDLE) && !empty_q;
    case (state_q)
      ST_IDLE: begin
        if (empty_q) begin
          if (stat_i.out_free) begin
            cmd_o.push_empty = 1'b1;
            empty_d = 1'b0;
          end
        end else if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.start_fill) begin
            state_d = ST_FILL;
          end else if (stat_i.start_pair) begin
            state_d = ST_CA;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CA: begin
        cmd_o.look_a = 1'b1;
        state_d = ST_CB;
      end
      ST_CB: begin
        cmd_o.look_b = 1'b1;
        state_d = ST_GA;
      end
      ST_GA: begin
        cmd_o.grid_a = 1'b1;
        state_d = ST_GB;
      end
      ST_GB: begin
        cmd_o.grid_b = 1'b1;
        state_d = ST_GC;
      end
      ST_GC: begin
        cmd_o.grid_c = 1'b1;
        if (stat_i.more_pair) begin
          cmd_o.next_pair = 1'b1;
          state_d = ST_CA;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.emit_go) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            empty_d = stat_i.empty_needed;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      empty_q <= empty_d;
    end
  end

endmodule

// ===== hdl/pfc_dp.sv =====
// Datapath: key tables, pairing state, cell arithmetic, result slots and output register.
module pfc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [pfc_pkg::OpW-1:0]           in_op_i,
  input  logic [pfc_pkg::SymW-1:0]          in_byte_i,
  input  logic                              in_eom_i,
  input  pfc_pkg::pfc_cmd_t                 cmd_i,
  output pfc_pkg::pfc_stat_t                stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pfc_pkg::SymW-1:0]          out_byte_o,
  output logic                              out_present_o,
  output logic                              out_final_o
);

  localparam int SymW  = pfc_pkg::SymW;
  localparam int CellW = pfc_pkg::CellW;
  localparam int SideW = pfc_pkg::SideW;

  // configuration
  logic [SymW-1:0] marker_q;
  logic            dir_q;

  // key state
  logic [pfc_pkg::SymCount-1:0] used_q;
  logic [pfc_pkg::FillW-1:0]    fill_ptr_q;
  logic                         key_done_q;
  logic [SymW-1:0]              fill_sym_q;

  // pairing state
  logic            pend_valid_q;
  logic [SymW-1:0] pend_sym_q;
  logic [SymW-1:0] a0_q, b0_q, a1_q;
  logic            second_q;
  logic            eom_q;
  logic            pair_idx_q;

  // lookup results
  logic [CellW-1:0] ca_q;
  logic [CellW-1:0] cell_b_q;

  // result slots
  logic [SymW-1:0]                  slot_q [pfc_pkg::SlotCount];
  logic [pfc_pkg::SlotCount-1:0]    keep_q;
  logic [pfc_pkg::SlotW-1:0]        emit_idx_q;

  // output register
  logic            out_valid_q;
  logic [SymW-1:0] out_byte_q;
  logic            out_present_q;
  logic            out_final_q;

  // RAM ports
  logic             cos_we, grid_we;
  logic [SymW-1:0]  cos_waddr;
  logic [CellW-1:0] grid_waddr;
  logic [CellW-1:0] cos_wdata;
  logic [SymW-1:0]  grid_wdata;
  logic [SymW-1:0]  cos_raddr;
  logic [CellW-1:0] grid_raddr;
  logic [CellW-1:0] cos_rdata;
  logic [SymW-1:0]  grid_rdata;

  logic            is_key, is_finish, is_data;
  logic            key_place, fill_place, grid_free;
  logic            pair_now;
  logic [SymW-1:0] cur_a, cur_b;
  logic [SideW-1:0] step;
  logic [SideW-1:0] ra, ka, rb, kb, nra, nka, nrb, nkb;
  logic [CellW-1:0] cell_a, cell_b;
  logic            keep_byte;
  logic [pfc_pkg::SlotW-1:0] slot_lo;
  logic [pfc_pkg::SlotCount-1:0] later_mask;
  logic            out_free;
  logic            emit_push, emit_final;

  assign is_key    = (in_op_i == pfc_pkg::OP_KEY);
  assign is_finish = (in_op_i == pfc_pkg::OP_FINISH);
  assign is_data   = (in_op_i == pfc_pkg::OP_DATA);
  assign grid_free = !fill_ptr_q[CellW];

  assign key_place  = cmd_i.accept && is_key && !key_done_q && grid_free &&
                      !used_q[in_byte_i];
  assign fill_place = cmd_i.fill_step && grid_free && !used_q[fill_sym_q];
  assign pair_now   = is_data && key_done_q && (pend_valid_q || in_eom_i);

  // table writes: key bytes at transfer, unused symbols during the sweep
  assign cos_we     = key_place || fill_place;
  assign grid_we    = cos_we;
  assign cos_waddr  = cmd_i.fill_step ? fill_sym_q : in_byte_i;
  assign grid_wdata = cos_waddr;
  assign cos_wdata  = fill_ptr_q[CellW-1:0];
  assign grid_waddr = fill_ptr_q[CellW-1:0];

  assign cur_a     = pair_idx_q ? a1_q : a0_q;
  assign cur_b     = pair_idx_q ? marker_q : b0_q;
  assign cos_raddr = cmd_i.look_a ? cur_a : cur_b;

  // Playfair rules on row/column nibbles
  always_comb begin
    step = dir_q ? pfc_pkg::StepBack : pfc_pkg::StepFwd;
    ra   = ca_q[CellW-1:SideW];
    ka   = ca_q[SideW-1:0];
    rb   = cos_rdata[CellW-1:SideW];
    kb   = cos_rdata[SideW-1:0];
    nra  = ra;
    nka  = ka;
    nrb  = rb;
    nkb  = kb;
    if (ra == rb) begin
      nka = ka + step;
      nkb = kb + step;
    end else if (ka == kb) begin
      nra = ra + step;
      nrb = rb + step;
    end else begin
      nka = kb;
      nkb = ka;
    end
    cell_a = {nra, nka};
    cell_b = {nrb, nkb};
  end

  assign grid_raddr = cmd_i.grid_a ? cell_a : cell_b_q;

  pfc_ram #(.Width(CellW), .Depth(pfc_pkg::SymCount)) u_cos_ram (
    .clk_i   (clk_i),
    .we_i    (cos_we),
    .waddr_i (cos_waddr),
    .wdata_i (cos_wdata),
    .raddr_i (cos_raddr),
    .rdata_o (cos_rdata)
  );

  pfc_ram #(.Width(SymW), .Depth(pfc_pkg::CellCount)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  // decrypt drops every marker byte
  assign keep_byte = !(dir_q && (grid_rdata == marker_q));
  assign slot_lo   = {pair_idx_q, cmd_i.grid_c};

  // hand-out
  assign out_free   = !out_valid_q || out_ready_i;
  assign later_mask = pfc_pkg::SlotCount'({pfc_pkg::SlotCount{1'b1}} << emit_idx_q) &
                      ~(pfc_pkg::SlotCount'(1) << emit_idx_q);
  assign emit_final = eom_q && ((keep_q & later_mask) == '0);
  assign emit_push  = cmd_i.emit_step && keep_q[emit_idx_q];

  assign stat_o.start_fill   = is_finish && !key_done_q;
  assign stat_o.start_pair   = pair_now;
  assign stat_o.fill_last    = (fill_sym_q == SymW'(pfc_pkg::SymCount - 1));
  assign stat_o.more_pair    = second_q && !pair_idx_q;
  assign stat_o.emit_go      = !keep_q[emit_idx_q] || out_free;
  assign stat_o.emit_last    = (emit_idx_q == pfc_pkg::SlotW'(pfc_pkg::SlotCount - 1));
  assign stat_o.empty_needed = eom_q && (keep_q == '0);
  assign stat_o.out_free     = out_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q     <= '0;
      dir_q        <= 1'b0;
      used_q       <= '0;
      fill_ptr_q   <= '0;
      key_done_q   <= 1'b0;
      fill_sym_q   <= '0;
      pend_valid_q <= 1'b0;
      pend_sym_q   <= '0;
      second_q     <= 1'b0;
      eom_q        <= 1'b0;
      pair_idx_q   <= 1'b0;
      keep_q       <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfc_pkg::RegMarker: marker_q <= cfg_data_i;
          pfc_pkg::RegDir:    dir_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (key_place) begin
        used_q[in_byte_i] <= 1'b1;
        fill_ptr_q        <= fill_ptr_q + 1'b1;
      end
      if (cmd_i.accept && stat_o.start_fill) begin
        fill_sym_q <= '0;
      end
      if (cmd_i.fill_step) begin
        fill_sym_q <= fill_sym_q + 1'b1;
        if (fill_place) begin
          used_q[fill_sym_q] <= 1'b1;
          fill_ptr_q         <= fill_ptr_q + 1'b1;
        end
        if (stat_o.fill_last) begin
          key_done_q <= 1'b1;
        end
      end
      if (cmd_i.accept && is_data && key_done_q) begin
        pair_idx_q <= 1'b0;
        emit_idx_q <= '0;
        keep_q     <= '0;
        eom_q      <= in_eom_i;
        second_q   <= 1'b0;
        pend_sym_q <= in_byte_i;
        if (!pend_valid_q) begin
          pend_valid_q <= !in_eom_i;
        end else if (pend_sym_q == in_byte_i) begin
          second_q     <= in_eom_i;
          pend_valid_q <= !in_eom_i;
        end else begin
          pend_valid_q <= 1'b0;
        end
      end
      if (cmd_i.next_pair) begin
        pair_idx_q <= 1'b1;
      end
      if (cmd_i.grid_b || cmd_i.grid_c) begin
        keep_q[slot_lo] <= keep_byte;
      end
      if (cmd_i.emit_step) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
      if (emit_push || cmd_i.push_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pair_now) begin
      a1_q <= in_byte_i;
      if (!pend_valid_q) begin
        a0_q <= in_byte_i;
        b0_q <= marker_q;
      end else if (pend_sym_q == in_byte_i) begin
        a0_q <= pend_sym_q;
        b0_q <= marker_q;
      end else begin
        a0_q <= pend_sym_q;
        b0_q <= in_byte_i;
      end
    end
    if (cmd_i.look_b) begin
      ca_q <= cos_rdata;
    end
    if (cmd_i.grid_a) begin
      cell_b_q <= cell_b;
    end
    if (cmd_i.grid_b || cmd_i.grid_c) begin
      slot_q[slot_lo] <= grid_rdata;
    end
    if (emit_push) begin
      out_byte_q    <= slot_q[emit_idx_q];
      out_present_q <= 1'b1;
      out_final_q   <= emit_final;
    end else if (cmd_i.push_empty) begin
      out_byte_q    <= '0;
      out_present_q <= 1'b0;
      out_final_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_present_o = out_present_q;
  assign out_final_o   = out_final_q;

endmodule

// ===== hdl/playfair_byte_cipher_16x16.sv =====
// Top level of the byte Playfair cipher over a 16x16 grid.
//
// Input stream (s_axis): one item per transfer. tuser carries the kind
// (key byte, finish key, data byte), tdata the byte, tlast the end of a
// message. Key bytes fill the grid row by row, repeats skipped; finish
// sweeps all 256 byte values into the free cells, then data bytes are paired.
// Output stream (m_axis): one enciphered or deciphered byte per transfer,
// tuser high when a byte is present, tlast on the last result of a message.
// Config port: cfg_idx_i 0 writes the marker byte, 1 the direction
// (0 encrypt, 1 decrypt); write only while the block is idle.
// A key byte is taken on its transfer alone. Finish then steps through all
// 256 byte values in order, writing each unused one into the next free
// cell through the single write port of the grid RAM. A data byte that only
// waits for its partner is taken on transfer; one forming a pair runs, per
// pair, two position lookups and two grid reads (one registered read port
// each), then 4 hand-out steps, one more for an empty end-of-message result.
// Reset clears the key (all symbols unused), pairing state and registers.
// A stalled receiver holds the output register; the sequencer waits and
// s_axis_tready is low until each item's results are in that register.
module playfair_byte_cipher_16x16 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
  input  logic [pfc_pkg::OpW-1:0]      s_axis_tuser,  // [1:0] operation
  input  logic                         s_axis_tlast,  // end_of_message
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
  output logic                         m_axis_tuser,  // [0] byte_present
  output logic                         m_axis_tlast   // final_item
);

  pfc_pkg::pfc_cmd_t  cmd;
  pfc_pkg::pfc_stat_t stat;

  pfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pfc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_op_i       (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .in_eom_i      (s_axis_tlast),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_present_o (m_axis_tuser),
    .out_final_o   (m_axis_tlast)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the 16x16 byte Playfair cipher: directed table, then random messages.
module tb;

  // The block ignores operation code three; named here as the package has no member for it.
  localparam logic [pfc_pkg::OpW-1:0] OpReserved   = 2'd3;
  localparam int                      UsePredictor = -1;
  localparam int                      CycleLimit   = 200000;
  localparam int                      SettleCycles = 40;

  // one result transfer: byte, byte-present flag, end of message
  typedef struct packed {
    logic [7:0] out_byte;
    logic       present;
    logic       last;
  } res_t;

  // one row of the directed table; n_typed < 0 means the predictor supplies the results
  typedef struct {
    logic [pfc_pkg::OpW-1:0] op;
    logic [7:0]              in_b;
    logic                    eom;
    int                      n_typed;
    res_t                    r0;
    res_t                    r1;
  } row_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [pfc_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = '0;
  logic [pfc_pkg::OpW-1:0]      s_axis_tuser  = '0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;

  playfair_byte_cipher_16x16 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cipher predictor: own copy of the key square and the pairing state
  // ---------------------------------------------------------------------------
  logic [7:0] key_grid [256];    // cell -> symbol
  logic [7:0] grid_pos [256];    // symbol -> cell, {row, col}
  bit         byte_taken [256];
  logic [8:0] fill_cnt  = '0;
  bit         key_done  = 1'b0;
  bit         held_ok   = 1'b0;
  logic [7:0] held_byte = '0;
  logic [7:0] mk_byte   = '0;    // marker register as last written
  bit         decrypt   = 1'b0;  // direction register as last written

  res_t step_res [$];   // results of the item just accepted
  res_t awaited  [$];   // results still owed by the block, oldest first
  row_t dir_rows [$];

  int snd_pct   = 28;   // sender idle chance per cycle, percent
  int rcv_pct   = 63;   // receiver stall chance per cycle, percent
  int calm_left = 0;
  int fails     = 0;
  int cycles    = 0;

  task automatic place_sym(input logic [7:0] s);
    if (fill_cnt < 9'd256 && !byte_taken[s]) begin
      key_grid[fill_cnt[7:0]] = s;
      grid_pos[s]             = fill_cnt[7:0];
      byte_taken[s]           = 1'b1;
      fill_cnt                = fill_cnt + 9'd1;
    end
  endtask

  // decrypt drops every marker byte, genuine ones too
  task automatic keep_byte(input logic [7:0] b);
    res_t r;
    if (!(decrypt && b == mk_byte)) begin
      r = {b, 1'b1, 1'b0};
      step_res = {step_res, r};
    end
  endtask

  task automatic encode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] ra, ka, rb, kb, st, t;
    ra = grid_pos[a][7:4];
    ka = grid_pos[a][3:0];
    rb = grid_pos[b][7:4];
    kb = grid_pos[b][3:0];
    st = decrypt ? 4'hF : 4'h1;   // 4-bit adds wrap round the square
    if (ra == rb) begin
      ka = ka + st;
      kb = kb + st;
    end else if (ka == kb) begin
      ra = ra + st;
      rb = rb + st;
    end else begin
      t  = ka;
      ka = kb;
      kb = t;
    end
    keep_byte(key_grid[{ra, ka}]);
    keep_byte(key_grid[{rb, kb}]);
  endtask

  task automatic cipher_step(input logic [pfc_pkg::OpW-1:0] op, input logic [7:0] b,
                             input logic eom);
    res_t r;
    int   s;
    step_res.delete();
    case (op)
      pfc_pkg::OP_KEY: begin
        if (!key_done) place_sym(b);
      end
      pfc_pkg::OP_FINISH: begin
        if (!key_done) begin
          for (s = 0; s < 256; s++) place_sym(8'(s));
          key_done = 1'b1;
        end
      end
      pfc_pkg::OP_DATA: begin
        if (key_done) begin
          if (!held_ok) begin
            if (eom) encode_pair(b, mk_byte);
            else begin
              held_byte = b;
              held_ok   = 1'b1;
            end
          end else if (held_byte == b) begin
            // equal neighbours: first one padded, second waits (or padded at end)
            encode_pair(held_byte, mk_byte);
            if (eom) encode_pair(b, mk_byte);
          end else begin
            encode_pair(held_byte, b);
            held_ok = 1'b0;
          end
          if (eom) begin
            held_ok = 1'b0;
            if (step_res.size() > 0) begin
              r      = step_res[step_res.size() - 1];
              r.last = 1'b1;
              step_res[step_res.size() - 1] = r;
            end else begin
              r      = '0;
              r.last = 1'b1;
              step_res = {step_res, r};
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // tvalid is left high after a transfer; the next call lowers it only if it idles
  task automatic send_item(input logic [pfc_pkg::OpW-1:0] op, input logic [7:0] b,
                           input logic eom);
    while ($urandom_range(0, 99) < snd_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cipher_step(op, b, eom);
  endtask

  task automatic send_checked(input logic [pfc_pkg::OpW-1:0] op, input logic [7:0] b,
                              input logic eom);
    send_item(op, b, eom);
    awaited = {awaited, step_res};
  endtask

  // sender holds off until every owed result has gone out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0);
  endtask

  // drained, plus room for an item that owes nothing but may still be busy
  task automatic settle();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pfc_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == pfc_pkg::RegMarker) mk_byte = val;
    else decrypt = val[0];
  endtask

  function automatic res_t byte_res(input logic [7:0] b, input logic tl);
    byte_res = {b, 1'b1, tl};
  endfunction

  task automatic add_row(input logic [pfc_pkg::OpW-1:0] op, input logic [7:0] b,
                         input logic eom, input int n, input res_t r0, input res_t r1);
    row_t row;
    row.op      = op;
    row.in_b    = b;
    row.eom     = eom;
    row.n_typed = n;
    row.r0      = r0;
    row.r1      = r1;
    dir_rows = {dir_rows, row};
  endtask

  // data symbols biased towards the marker, repeats and same-row/column partners
  function automatic logic [7:0] pick_symbol(input logic [7:0] prev);
    logic [7:0] spot;
    spot = grid_pos[prev];
    case ($urandom_range(0, 9))
      0, 1:    return mk_byte;
      2:       return prev;
      3, 4:    return key_grid[{spot[7:4], 4'($urandom)}];
      5:       return key_grid[{4'($urandom), spot[3:0]}];
      default: return 8'($urandom);
    endcase
  endfunction

  // messages of random content; a few ignored items and unterminated messages mixed in
  task automatic random_phase(input int n_data);
    int                      sent, len, k;
    logic [7:0]              prev, cur;
    logic [pfc_pkg::OpW-1:0] nop;
    bit                      open_end;
    sent = 0;
    prev = 8'($urandom);
    while (sent < n_data) begin
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 2))
          0:       nop = pfc_pkg::OP_KEY;
          1:       nop = pfc_pkg::OP_FINISH;
          default: nop = OpReserved;
        endcase
        send_checked(nop, 8'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) drain_results();
        len      = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        open_end = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          cur = pick_symbol(prev);
          send_checked(pfc_pkg::OP_DATA, cur, (k == len - 1) && !open_end);
          prev = cur;
        end
        sent += len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls with calm stretches, and the result check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rcv_pct != 0 && calm_left == 0 && $urandom_range(0, 99) == 0) calm_left = 24;
    if (calm_left > 0) calm_left--;
    m_axis_tready <= rst_ni && (calm_left > 0 || $urandom_range(0, 99) >= rcv_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      if (awaited.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: expected none, actual byte %02h present %0b last %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = awaited.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          fails++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, m_axis_tdata);
        end
        if (m_axis_tuser !== want.present) begin
          fails++;
          $display("%0t: byte_present expected %0b actual %0b", $time, want.present, m_axis_tuser);
        end
        if (m_axis_tlast !== want.last) begin
          fails++;
          $display("%0t: final_item expected %0b actual %0b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  // Key 00 FF 41 then the sweep gives row 0 = 00 FF 41 01 02 .. 0D and
  // row 1 = 0E 0F .. 1D, row 2 starting 1E. Marker is 00 and direction
  // encrypt after reset, so the short rows below read off directly.
  initial begin
    logic [7:0] marks [6];
    bit         dirs  [6];
    int         ph;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored before the key exists
    add_row(pfc_pkg::OP_DATA,   8'h41, 1'b1, 0, '0, '0);
    add_row(OpReserved,         8'hFF, 1'b1, 0, '0, '0);
    // key, with repeats skipped
    add_row(pfc_pkg::OP_KEY,    8'h00, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_KEY,    8'hFF, 1'b1, 0, '0, '0);
    add_row(pfc_pkg::OP_KEY,    8'h00, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_KEY,    8'h41, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_KEY,    8'h41, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_FINISH, 8'hA5, 1'b0, 0, '0, '0);
    // second finish and late key byte change nothing
    add_row(pfc_pkg::OP_FINISH, 8'h5A, 1'b1, 0, '0, '0);
    add_row(pfc_pkg::OP_KEY,    8'h99, 1'b0, 0, '0, '0);
    // same row, shift right
    add_row(pfc_pkg::OP_DATA,   8'h00, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'hFF, 1'b1, 2, byte_res(8'hFF, 1'b0), byte_res(8'h41, 1'b1));
    // same row, wrap from the last column
    add_row(pfc_pkg::OP_DATA,   8'h41, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'h0D, 1'b1, 2, byte_res(8'h01, 1'b0), byte_res(8'h00, 1'b1));
    // lone byte at message end, padded with the marker
    add_row(pfc_pkg::OP_DATA,   8'h05, 1'b1, 2, byte_res(8'h06, 1'b0), byte_res(8'hFF, 1'b1));
    // same column
    add_row(pfc_pkg::OP_DATA,   8'h00, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'h0E, 1'b1, 2, byte_res(8'h0E, 1'b0), byte_res(8'h1E, 1'b1));
    // rectangle, columns swapped
    add_row(pfc_pkg::OP_DATA,   8'h00, 1'b0, 0, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'h0F, 1'b1, 2, byte_res(8'hFF, 1'b0), byte_res(8'h0E, 1'b1));
    // equal neighbours mid-message, then at message end (four results)
    add_row(pfc_pkg::OP_DATA,   8'h07, 1'b0, UsePredictor, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'h07, 1'b0, UsePredictor, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'h08, 1'b0, UsePredictor, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'hFE, 1'b0, UsePredictor, '0, '0);
    add_row(pfc_pkg::OP_DATA,   8'hFE, 1'b1, UsePredictor, '0, '0);
    add_row(OpReserved,         8'h00, 1'b1, 0, '0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].n_typed == UsePredictor) begin
        send_checked(dir_rows[i].op, dir_rows[i].in_b, dir_rows[i].eom);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].in_b, dir_rows[i].eom);
        if (dir_rows[i].n_typed > 0) awaited = {awaited, dir_rows[i].r0};
        if (dir_rows[i].n_typed > 1) awaited = {awaited, dir_rows[i].r1};
      end
    end
    settle();

    // register settings per phase, extremes included
    marks = '{8'hFF, 8'h00, 8'($urandom), 8'hFF, 8'($urandom), 8'($urandom)};
    dirs  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    for (ph = 0; ph < 6; ph++) begin
      // sender light / receiver heavy, then swapped, then flat out
      case (ph / 2)
        0: begin snd_pct = 28; rcv_pct = 63; end
        1: begin snd_pct = 63; rcv_pct = 28; end
        default: begin snd_pct = 0; rcv_pct = 0; end
      endcase
      write_reg(pfc_pkg::RegMarker, marks[ph]);
      write_reg(pfc_pkg::RegDir, {7'd0, dirs[ph]});
      random_phase(56);
      settle();
    end

    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== playfair_byte_cipher_16x16.f =====
hdl/pfc_pkg.sv
hdl/pfc_ram.sv
hdl/pfc_ctrl.sv
hdl/pfc_dp.sv
hdl/playfair_byte_cipher_16x16.sv
bench/tb.sv
